/* rtl/core/segh_pkg.sv */
`default_nettype none
package segh_pkg;

  // datapath widths
  localparam int unsigned DW        = 136;
  localparam int unsigned MUL_AW    = 102;
  localparam int unsigned MUL_BW    = 34;
  localparam int unsigned MUL_SLICE = 34;
  localparam int unsigned LANES     = 9;
  localparam int unsigned NPAIR     = 6;

  // iteration counts
  localparam int unsigned RT_STEPS  = 34;
  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned DIV_STG   = DIV_STEPS + 2;

  // stage map of the pipeline
  localparam int unsigned ST_D    = 0;
  localparam int unsigned ST_SQ   = 1;
  localparam int unsigned ST_SUM  = 2;
  localparam int unsigned ST_RT0  = 3;
  localparam int unsigned ST_DLT  = ST_RT0 + RT_STEPS;
  localparam int unsigned ST_M1   = ST_DLT + 1;
  localparam int unsigned ST_M2   = ST_M1 + 1;
  localparam int unsigned ST_M3   = ST_M2 + 2;
  localparam int unsigned ST_ADD  = ST_M3 + 2;
  localparam int unsigned ST_NUM  = ST_ADD + 1;
  localparam int unsigned ST_DIV0 = ST_NUM + 1;
  localparam int unsigned ST_OUT  = ST_DIV0 + DIV_STG;
  localparam int unsigned N_STG   = ST_OUT + 1;

  // register indexes
  localparam int unsigned CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_REST  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_STIFF = 2'd1;
  localparam logic [30:0] REG_RESET = 31'd65536;

  // saturation limits
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;

  // hessian pairs xx xy xz yy yz zz
  localparam int HI [NPAIR] = '{0, 0, 0, 1, 1, 2};
  localparam int HJ [NPAIR] = '{0, 1, 2, 1, 2, 2};
  localparam logic [NPAIR-1:0] DIAG = 6'b101001;

  typedef logic [N_STG-1:0] stg_en_t;

  typedef struct packed {
    logic              deg;
    logic [2:0]        gsg;
    logic [NPAIR-1:0]  hsg;
    logic [33:0]       len;
  } side_t;

  typedef struct packed {
    logic        deg;
    logic [31:0] energy;
  } tail_t;

endpackage
`default_nettype wire

/* rtl/core/segh_if.sv */
`default_nettype none
interface segh_pts_if;
  logic valid;
  logic ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  modport source(output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 input ready);
  modport sink(input valid, first_x, first_y, first_z, second_x, second_y, second_z,
               output ready);
endinterface

interface segh_res_if;
  logic valid;
  logic ready;
  logic [31:0] energy;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  logic signed [31:0] grad_z;
  logic signed [31:0] hess_xx;
  logic signed [31:0] hess_xy;
  logic signed [31:0] hess_xz;
  logic signed [31:0] hess_yy;
  logic signed [31:0] hess_yz;
  logic signed [31:0] hess_zz;
  logic degenerate;
  modport source(output valid, energy, grad_x, grad_y, grad_z, hess_xx, hess_xy, hess_xz,
                 hess_yy, hess_yz, hess_zz, degenerate, input ready);
  modport sink(input valid, energy, grad_x, grad_y, grad_z, hess_xx, hess_xy, hess_xz,
               hess_yy, hess_yz, hess_zz, degenerate, output ready);
endinterface

interface segh_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [30:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/spring_energy_gradient_hessian.sv */
`default_nettype none
// Hookean spring evaluator: from two Q16.16 endpoints and the rest length and
// stiffness registers it returns energy, gradient on the first endpoint and the
// six unique Hessian entries, all Q16.16 with saturation; coinciding endpoints
// set degenerate and zero gradient and Hessian. One item is accepted per clock
// while the output is not stalled; the bit-per-stage square root and the
// bit-per-stage dividers (one divider per gradient and Hessian lane) make up
// most of the pipeline depth. While a result waits on the output, an item is
// still taken into the first stage if that stage is empty.
// Write registers only while no item is in flight.
module spring_energy_gradient_hessian
  import segh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  segh_pts_if.sink    pts,
  segh_res_if.source  res,
  segh_cfg_if.sink    cfg
);

  logic [30:0] rest_len, stiffness;
  stg_en_t en;
  logic out_valid;
  logic [2:0][31:0] p1, p2;
  logic [LANES-1:0][DW-1:0] num, den;
  logic [LANES-1:0] neg;
  logic [LANES-1:0][31:0] qres;
  logic [31:0] energy_n;
  logic deg_n;
  tail_t tl [DIV_STG];
  logic [LANES-1:0][31:0] out_q;
  logic [31:0] out_e;
  logic out_d;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rest_len  <= REG_RESET;
      stiffness <= REG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_REST:  rest_len  <= cfg.data;
        REG_STIFF: stiffness <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  segh_ctl u_ctl (
    .clk(clk), .rst(rst), .in_valid(pts.valid), .out_ready(res.ready),
    .en(en), .out_valid(out_valid)
  );
  assign pts.ready = en[ST_D];

  assign p1 = {pts.first_z, pts.first_y, pts.first_x};
  assign p2 = {pts.second_z, pts.second_y, pts.second_x};

  segh_arith u_arith (
    .clk(clk), .en(en), .p1(p1), .p2(p2),
    .rest_len(rest_len), .stiffness(stiffness),
    .num(num), .den(den), .neg(neg), .energy(energy_n), .deg(deg_n)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_div
    segh_div u_div (
      .clk(clk), .en(en[ST_DIV0 +: DIV_STG]), .num(num[l]), .den(den[l]),
      .neg(neg[l]), .res(qres[l])
    );
  end

  // energy and flag ride alongside the dividers
  for (genvar k = 0; k < DIV_STG; k++) begin : g_tail
    always_ff @(posedge clk) begin
      if (en[ST_DIV0+k]) begin
        tl[k] <= (k == 0) ? tail_t'{deg: deg_n, energy: energy_n} : tl[(k == 0) ? 0 : k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_e <= tl[DIV_STG-1].energy;
      out_d <= tl[DIV_STG-1].deg;
      out_q <= tl[DIV_STG-1].deg ? '0 : qres;
    end
  end

  assign res.valid      = out_valid;
  assign res.energy     = out_e;
  assign res.degenerate = out_d;
  assign res.grad_x     = out_q[0];
  assign res.grad_y     = out_q[1];
  assign res.grad_z     = out_q[2];
  assign res.hess_xx    = out_q[3];
  assign res.hess_xy    = out_q[4];
  assign res.hess_xz    = out_q[5];
  assign res.hess_yy    = out_q[6];
  assign res.hess_yz    = out_q[7];
  assign res.hess_zz    = out_q[8];

endmodule
`default_nettype wire

/* rtl/core/segh_ctl.sv */
`default_nettype none
module segh_ctl
  import segh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    out_ready,
  output stg_en_t en,
  output logic    out_valid
);

  logic [N_STG-1:0] v;
  logic adv;

  // whole pipe moves when the output slot frees; the entry stage also fills a bubble
  assign adv = !v[N_STG-1] || out_ready;

  always_comb begin
    en = {N_STG{adv}};
    en[0] = adv || !v[0];
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      if (adv) begin
        v[N_STG-1:1] <= v[N_STG-2:0];
      end
    end
  end

  assign out_valid = v[N_STG-1];

endmodule
`default_nettype wire

/* rtl/core/segh_mul.sv */
`default_nettype none
module segh_mul
  import segh_pkg::*;
(
  input  logic              clk,
  input  logic [1:0]        en,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  output logic [DW-1:0]     p
);

  localparam int unsigned NSL = MUL_AW / MUL_SLICE;
  localparam int unsigned PPW = MUL_SLICE + MUL_BW;

  logic [NSL-1:0][PPW-1:0] pp;
  logic [DW-1:0] acc;

  // partial products, one slice of a per multiplier
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int t = 0; t < NSL; t++) begin
        pp[t] <= a[t*MUL_SLICE +: MUL_SLICE] * b;
      end
    end
  end

  // aligned sum of the slices
  always_comb begin
    acc = '0;
    for (int t = 0; t < NSL; t++) begin
      acc = acc + (DW'(pp[t]) << (t * MUL_SLICE));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p <= acc;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/segh_div.sv */
`default_nettype none
module segh_div
  import segh_pkg::*;
(
  input  logic               clk,
  input  logic [DIV_STG-1:0] en,
  input  logic [DW-1:0]      num,
  input  logic [DW-1:0]      den,
  input  logic               neg,
  output logic [31:0]        res
);

  logic [DW-1:0] n0, d0, n1, d1;
  logic s0, s1, o1;
  logic [DW-1:0] rm [DIV_STEPS];
  logic [DW-1:0] dv [DIV_STEPS];
  logic [30:0]   qv [DIV_STEPS];
  logic          sg [DIV_STEPS];
  logic          ov [DIV_STEPS];
  logic [30:0]   q;

  // round half up by adding half the divisor
  always_ff @(posedge clk) begin
    if (en[0]) begin
      n0 <= num + (den >> 1);
      d0 <= den;
      s0 <= neg;
    end
  end

  // quotient of 2^31 or more saturates
  always_ff @(posedge clk) begin
    if (en[1]) begin
      o1 <= n0 >= (d0 << DIV_STEPS);
      n1 <= n0;
      d1 <= d0;
      s1 <= s0;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int unsigned SH = DIV_STEPS - 1 - k;
    logic [DW-1:0] r_p, d_p, t;
    logic [30:0] q_p;
    logic s_p, o_p, ge;
    if (k == 0) begin : g_first
      assign r_p = n1;
      assign d_p = d1;
      assign q_p = '0;
      assign s_p = s1;
      assign o_p = o1;
    end else begin : g_next
      assign r_p = rm[k-1];
      assign d_p = dv[k-1];
      assign q_p = qv[k-1];
      assign s_p = sg[k-1];
      assign o_p = ov[k-1];
    end
    assign t  = d_p << SH;
    assign ge = r_p >= t;
    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        rm[k] <= ge ? r_p - t : r_p;
        dv[k] <= d_p;
        qv[k] <= {q_p[29:0], ge};
        sg[k] <= s_p;
        ov[k] <= o_p;
      end
    end
  end

  // signed saturating result
  assign q = qv[DIV_STEPS-1];
  always_comb begin
    if (sg[DIV_STEPS-1]) begin
      res = ov[DIV_STEPS-1] ? S32_MIN : 32'(-{1'b0, q});
    end else begin
      res = ov[DIV_STEPS-1] ? S32_MAX : {1'b0, q};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/segh_arith.sv */
`default_nettype none
module segh_arith
  import segh_pkg::*;
(
  input  logic                       clk,
  input  stg_en_t                    en,
  input  logic [2:0][31:0]           p1,
  input  logic [2:0][31:0]           p2,
  input  logic [30:0]                rest_len,
  input  logic [30:0]                stiffness,
  output logic [LANES-1:0][DW-1:0]   num,
  output logic [LANES-1:0][DW-1:0]   den,
  output logic [LANES-1:0]           neg,
  output logic [31:0]                energy,
  output logic                       deg
);

  // difference and magnitude
  logic [2:0][32:0] dd;
  logic [2:0][32:0] ad0, ad1, ad2;
  logic [2:0] ng0, ng1, ng2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = {p1[i][31], p1[i]} - {p2[i][31], p2[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_D]) begin
      for (int i = 0; i < 3; i++) begin
        ad0[i] <= dd[i][32] ? (~dd[i] + 33'd1) : dd[i];
        ng0[i] <= dd[i][32];
      end
    end
  end

  // squares
  logic [2:0][65:0] sq1;
  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= ad0[i] * ad0[i];
      end
      ad1 <= ad0;
      ng1 <= ng0;
    end
  end

  // squared length
  logic [65:0] s2;
  logic dg2;
  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      s2  <= sq1[0] + sq1[1] + sq1[2];
      dg2 <= (sq1[0] == '0) && (sq1[1] == '0) && (sq1[2] == '0);
      ad2 <= ad1;
      ng2 <= ng1;
    end
  end

  // square root, one result bit per stage
  logic [36:0]      rm  [RT_STEPS];
  logic [33:0]      rt  [RT_STEPS];
  logic [67:0]      sv  [RT_STEPS];
  logic [2:0][32:0] adr [RT_STEPS];
  logic [2:0]       ngr [RT_STEPS];
  logic             dgr [RT_STEPS];

  for (genvar j = 0; j < RT_STEPS; j++) begin : g_rt
    logic [36:0] rem_p, rem_sh, trial;
    logic [33:0] root_p;
    logic [67:0] sv_p;
    logic [2:0][32:0] ad_p;
    logic [2:0] ng_p;
    logic dg_p, ge;
    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign sv_p   = {2'b00, s2};
      assign ad_p   = ad2;
      assign ng_p   = ng2;
      assign dg_p   = dg2;
    end else begin : g_next
      assign rem_p  = rm[j-1];
      assign root_p = rt[j-1];
      assign sv_p   = sv[j-1];
      assign ad_p   = adr[j-1];
      assign ng_p   = ngr[j-1];
      assign dg_p   = dgr[j-1];
    end
    assign rem_sh = {rem_p[34:0], sv_p[67:66]};
    assign trial  = {1'b0, root_p, 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (en[ST_RT0+j]) begin
        rm[j]  <= ge ? rem_sh - trial : rem_sh;
        rt[j]  <= {root_p[32:0], ge};
        sv[j]  <= {sv_p[65:0], 2'b00};
        adr[j] <= ad_p;
        ngr[j] <= ng_p;
        dgr[j] <= dg_p;
      end
    end
  end

  // stretch against rest length
  logic [33:0] len_f, len3, adl3;
  logic dneg3, dg3;
  logic [2:0][32:0] ad3;
  logic [2:0] ng3;

  assign len_f = rt[RT_STEPS-1];

  always_ff @(posedge clk) begin
    if (en[ST_DLT]) begin
      dneg3 <= len_f < 34'(rest_len);
      adl3  <= (len_f < 34'(rest_len)) ? 34'(rest_len) - len_f
                                        : len_f - 34'(rest_len);
      len3  <= len_f;
      dg3   <= dgr[RT_STEPS-1];
      ad3   <= adr[RT_STEPS-1];
      ng3   <= ngr[RT_STEPS-1];
    end
  end

  // first product round and signs
  logic [67:0] a2, l2m;
  logic [64:0] ak;
  logic [NPAIR-1:0][65:0] pp;
  logic [2:0][32:0] ad4;
  side_t sd4;

  always_ff @(posedge clk) begin
    if (en[ST_M1]) begin
      a2  <= adl3 * adl3;
      ak  <= 65'(adl3) * 65'(stiffness);
      l2m <= len3 * len3;
      for (int m = 0; m < NPAIR; m++) begin
        pp[m]     <= ad3[HI[m]] * ad3[HJ[m]];
        sd4.hsg[m] <= ng3[HI[m]] ^ ng3[HJ[m]];
      end
      for (int i = 0; i < 3; i++) begin
        sd4.gsg[i] <= dneg3 ^ ng3[i];
      end
      sd4.len <= len3;
      sd4.deg <= dg3;
      ad4     <= ad3;
    end
  end

  // second product round
  logic [DW-1:0] e5, l3_5, l2k5;
  logic [2:0][DW-1:0] gk5;
  logic [NPAIR-1:0][DW-1:0] pk5;
  side_t sd5a, sd5;

  segh_mul u_m_e (.clk(clk), .en(en[ST_M2 +: 2]), .a(MUL_AW'(a2)),
                  .b(MUL_BW'(stiffness)), .p(e5));
  segh_mul u_m_l3 (.clk(clk), .en(en[ST_M2 +: 2]), .a(MUL_AW'(l2m)),
                   .b(sd4.len), .p(l3_5));
  segh_mul u_m_l2k (.clk(clk), .en(en[ST_M2 +: 2]), .a(MUL_AW'(l2m)),
                    .b(MUL_BW'(stiffness)), .p(l2k5));
  for (genvar i = 0; i < 3; i++) begin : g_gk
    segh_mul u_m_gk (.clk(clk), .en(en[ST_M2 +: 2]), .a(MUL_AW'(ak)),
                     .b(MUL_BW'(ad4[i])), .p(gk5[i]));
  end
  for (genvar m = 0; m < NPAIR; m++) begin : g_pk
    segh_mul u_m_pk (.clk(clk), .en(en[ST_M2 +: 2]), .a(MUL_AW'(pp[m])),
                     .b(MUL_BW'(stiffness)), .p(pk5[m]));
  end

  always_ff @(posedge clk) begin
    if (en[ST_M2]) begin
      sd5a <= sd4;
    end
    if (en[ST_M2+1]) begin
      sd5 <= sd5a;
    end
  end

  // third product round
  logic [DW-1:0] ul7, kl3_7;
  logic [NPAIR-1:0][DW-1:0] o7;
  logic [DW-1:0] e6a, e6, l3_6a, l3_6;
  logic [2:0][DW-1:0] gk6a, gk6;
  side_t sd6a, sd6;

  segh_mul u_m_ul (.clk(clk), .en(en[ST_M3 +: 2]), .a(l2k5[MUL_AW-1:0]),
                   .b(MUL_BW'(rest_len)), .p(ul7));
  segh_mul u_m_kl3 (.clk(clk), .en(en[ST_M3 +: 2]), .a(l3_5[MUL_AW-1:0]),
                    .b(MUL_BW'(stiffness)), .p(kl3_7));
  for (genvar m = 0; m < NPAIR; m++) begin : g_o
    segh_mul u_m_o (.clk(clk), .en(en[ST_M3 +: 2]), .a(pk5[m][MUL_AW-1:0]),
                    .b(MUL_BW'(rest_len)), .p(o7[m]));
  end

  always_ff @(posedge clk) begin
    if (en[ST_M3]) begin
      e6a   <= e5;
      l3_6a <= l3_5;
      gk6a  <= gk5;
      sd6a  <= sd5;
    end
    if (en[ST_M3+1]) begin
      e6   <= e6a;
      l3_6 <= l3_6a;
      gk6  <= gk6a;
      sd6  <= sd6a;
    end
  end

  // diagonal sums and energy rounding
  logic [DW-1:0] er;
  logic [NPAIR-1:0][DW-1:0] pd8;
  logic [DW-1:0] ul8, l3_8;
  logic [2:0][DW-1:0] gk8;
  logic [31:0] en8;
  side_t sd8;

  assign er = e6 + (DW'(1) << 32);

  always_ff @(posedge clk) begin
    if (en[ST_ADD]) begin
      for (int m = 0; m < NPAIR; m++) begin
        pd8[m] <= DIAG[m] ? kl3_7 + o7[m] : o7[m];
      end
      en8  <= (|er[DW-1:65]) ? '1 : er[64:33];
      ul8  <= ul7;
      l3_8 <= l3_6;
      gk8  <= gk6;
      sd8  <= sd6;
    end
  end

  // divider operands per lane
  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= gk8[i];
        den[i] <= DW'({sd8.len, 16'd0});
        neg[i] <= sd8.gsg[i];
      end
      for (int m = 0; m < NPAIR; m++) begin
        den[3+m] <= l3_8;
        if (DIAG[m]) begin
          num[3+m] <= (pd8[m] >= ul8) ? pd8[m] - ul8 : ul8 - pd8[m];
          neg[3+m] <= pd8[m] < ul8;
        end else begin
          num[3+m] <= pd8[m];
          neg[3+m] <= sd8.hsg[m];
        end
      end
      energy <= en8;
      deg    <= sd8.deg;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/segh_chk.sv */
`default_nettype none
module segh_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pts_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] energy,
  input wire logic [31:0] grad_x,
  input wire logic [31:0] grad_y,
  input wire logic [31:0] grad_z,
  input wire logic [31:0] hess_xx,
  input wire logic [31:0] hess_xy,
  input wire logic [31:0] hess_xz,
  input wire logic [31:0] hess_yy,
  input wire logic [31:0] hess_yz,
  input wire logic [31:0] hess_zz,
  input wire logic        degenerate
);

  // coinciding endpoints give no gradient
  a_deg_grad: assert property (@(posedge clk) disable iff (rst)
    res_valid && degenerate |-> grad_x == 0 && grad_y == 0 && grad_z == 0)
    else $error("degenerate item with nonzero gradient");

  // coinciding endpoints give no hessian
  a_deg_hess: assert property (@(posedge clk) disable iff (rst)
    res_valid && degenerate |-> hess_xx == 0 && hess_xy == 0 && hess_xz == 0 &&
      hess_yy == 0 && hess_yz == 0 && hess_zz == 0)
    else $error("degenerate item with nonzero hessian");

  // a free output slot always lets an item in
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !res_valid || res_ready |-> pts_ready)
    else $error("input stalled with output free");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(energy) && $stable(grad_x))
    else $error("result changed while stalled");

endmodule

bind spring_energy_gradient_hessian segh_chk u_chk (
  .clk(clk), .rst(rst), .pts_ready(pts.ready), .res_valid(res.valid),
  .res_ready(res.ready), .energy(res.energy), .grad_x(res.grad_x),
  .grad_y(res.grad_y), .grad_z(res.grad_z), .hess_xx(res.hess_xx),
  .hess_xy(res.hess_xy), .hess_xz(res.hess_xz), .hess_yy(res.hess_yy),
  .hess_yz(res.hess_yz), .hess_zz(res.hess_zz), .degenerate(res.degenerate)
);
`default_nettype wire

/* tb/tb_spring_energy_gradient_hessian.sv */
`default_nettype none
module tb_spring_energy_gradient_hessian;
  import segh_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = 90;
  localparam logic [1:0] REG_UNUSED_A = 2'd2;
  localparam logic [1:0] REG_UNUSED_B = 2'd3;
  localparam logic [30:0] REG_MAX     = 31'h7FFF_FFFF;

  typedef struct {
    logic signed [31:0] p1 [3];
    logic signed [31:0] p2 [3];
  } spring_pts_t;

  typedef struct packed {
    logic [31:0]      energy;
    logic [2:0][31:0] grad;
    logic [5:0][31:0] hess;
    logic             deg;
  } spring_eval_t;

  logic clk;
  logic rst;

  segh_pts_if pts_if ();
  segh_res_if res_if ();
  segh_cfg_if cfg_if ();

  spring_energy_gradient_hessian uut (
    .clk (clk),
    .rst (rst),
    .pts (pts_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // mirror of the configuration registers
  logic [30:0] rest_q;
  logic [30:0] stiff_q;

  spring_eval_t expected_evals [$];
  int unsigned  mismatches;
  bit           no_idle;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // rounded quotient, magnitude half up
  function automatic logic [191:0] div_round(logic [191:0] num, logic [191:0] den);
    return (num + (den >> 1)) / den;
  endfunction

  // saturate a magnitude with sign to signed 32 bits
  function automatic logic [31:0] sat_s32(logic [191:0] mag, logic neg);
    if (neg) begin
      if (mag >= 192'h8000_0000) return S32_MIN;
      return 32'h0 - mag[31:0];
    end
    if (mag > 192'h7FFF_FFFF) return S32_MAX;
    return mag[31:0];
  endfunction

  // energy, gradient and hessian of one spring
  function automatic spring_eval_t eval_spring(spring_pts_t sp, logic [30:0] rest,
                                               logic [30:0] stiff);
    spring_eval_t  e;
    logic [191:0]  s, t, u, pp, c, len, l2, l3, adelta, k, r, kr;
    logic [191:0]  ad [3];
    logic [63:0]   prod;
    logic          neg [3];
    logic          dneg;
    logic signed [33:0] d;
    int a, b;
    e = '0;
    k = {161'b0, stiff};
    r = {161'b0, rest};
    kr = k * r;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      d = 34'(sp.p1[i]) - 34'(sp.p2[i]);
      neg[i] = d < 0;
      ad[i] = neg[i] ? 192'(-d) : 192'(d);
      s = s + ad[i] * ad[i];
    end
    e.deg = (s == '0);
    len = '0;
    for (int bt = 33; bt >= 0; bt--) begin
      c = len | (192'd1 << bt);
      if (c * c <= s) len = c;
    end
    dneg = len < r;
    adelta = dneg ? r - len : len - r;
    t = div_round(adelta * adelta * k, 192'd1 << 33);
    e.energy = (t > 192'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    if (e.deg) return e;
    for (int i = 0; i < 3; i++)
      e.grad[2-i] = sat_s32(div_round(adelta * k * ad[i], len << 16), dneg != neg[i]);
    l2 = len * len;
    l3 = l2 * len;
    for (int i = 0; i < 6; i++) begin
      a = HI[i];
      b = HJ[i];
      prod = ad[a][63:0] * ad[b][63:0];
      if (a != b) begin
        e.hess[5-i] = sat_s32(div_round({128'b0, prod} * kr, l3), neg[a] != neg[b]);
      end else begin
        pp = l3 * k + {128'b0, prod} * kr;
        u = l2 * kr;
        if (pp >= u) e.hess[5-i] = sat_s32(div_round(pp - u, l3), 1'b0);
        else e.hess[5-i] = sat_s32(div_round(u - pp, l3), 1'b1);
      end
    end
    return e;
  endfunction

  // send one item, predict on acceptance
  task automatic send_spring(spring_pts_t sp);
    if (!no_idle && $urandom_range(0, 99) < 21) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        pts_if.valid = 1'b0;
      end
    end
    @(negedge clk);
    pts_if.valid    = 1'b1;
    pts_if.first_x  = sp.p1[0];
    pts_if.first_y  = sp.p1[1];
    pts_if.first_z  = sp.p1[2];
    pts_if.second_x = sp.p2[0];
    pts_if.second_y = sp.p2[1];
    pts_if.second_z = sp.p2[2];
    forever begin
      @(posedge clk);
      if (pts_if.ready) break;
    end
    expected_evals.insert(expected_evals.size(), eval_spring(sp, rest_q, stiff_q));
  endtask

  // register write once the pipeline is empty
  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(negedge clk);
    pts_if.valid = 1'b0;
    wait (expected_evals.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    forever begin
      @(posedge clk);
      if (cfg_if.ready) break;
    end
    if (idx == REG_REST) rest_q = val;
    else if (idx == REG_STIFF) stiff_q = val;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
      2:       return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
      3:       return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic spring_pts_t rand_spring();
    spring_pts_t sp;
    for (int i = 0; i < 3; i++) begin
      sp.p1[i] = rand_coord();
      sp.p2[i] = $urandom_range(0, 2) == 0 ? rand_coord()
               : sp.p1[i] + ($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    end
    // coinciding endpoints now and then
    if ($urandom_range(0, 29) == 0) sp.p2 = sp.p1;
    return sp;
  endfunction

  function automatic spring_pts_t mk_spring(int x1, int y1, int z1, int x2, int y2, int z2);
    spring_pts_t sp;
    sp.p1 = '{x1, y1, z1};
    sp.p2 = '{x2, y2, z2};
    return sp;
  endfunction

  // extremes, degenerate springs, unit and stretched springs
  task automatic test_directed();
    int mx, mn;
    mx = S32_MAX;
    mn = S32_MIN;
    send_spring(mk_spring(0, 0, 0, 0, 0, 0));
    send_spring(mk_spring(mx, mn, 12345, mx, mn, 12345));
    send_spring(mk_spring(mx, mx, mx, mn, mn, mn));
    send_spring(mk_spring(mn, mn, mn, mx, mx, mx));
    send_spring(mk_spring(mx, mn, mx, mn, mx, mn));
    send_spring(mk_spring(65536, 0, 0, 0, 0, 0));
    send_spring(mk_spring(0, -65536, 0, 0, 0, 0));
    send_spring(mk_spring(0, 0, 131072, 0, 0, 0));
    send_spring(mk_spring(32768, 0, 0, 0, 0, 0));
    send_spring(mk_spring(1, 0, 0, 0, 0, 0));
    send_spring(mk_spring(0, 0, 0, 1, 1, 1));
    send_spring(mk_spring(65536, 65536, 65536, -65536, -65536, -65536));
    send_spring(mk_spring(37837, -37837, 37837, 0, 0, 0));
    send_spring(mk_spring(mx, 0, 0, 0, 0, 0));
    send_spring(mk_spring(mn, 0, 0, 0, 0, 0));
    send_spring(mk_spring(-1, -1, -1, -1, -1, -1));
  endtask

  // register corners, including ignored indexes
  task automatic test_config_corners();
    logic [30:0] rests [4];
    logic [30:0] stiffs [4];
    rests  = '{31'd0, REG_MAX, REG_MAX, 31'd1};
    stiffs = '{REG_MAX, 31'd0, REG_MAX, 31'd1};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_REST, rests[p]);
      write_reg(REG_STIFF, stiffs[p]);
      test_directed();
      repeat (40) send_spring(rand_spring());
    end
    write_reg(REG_UNUSED_A, 31'h1234_5678);
    write_reg(REG_UNUSED_B, REG_MAX);
    repeat (20) send_spring(rand_spring());
  endtask

  // random springs under several register settings
  task automatic test_random_springs();
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: write_reg(REG_REST, 31'($urandom_range(0, 32'h0004_0000)));
        1: write_reg(REG_REST, 31'($urandom()));
        default: write_reg(REG_REST, REG_RESET);
      endcase
      write_reg(REG_STIFF, (p % 3 == 0) ? 31'($urandom()) : 31'($urandom_range(0, 32'h000F_FFFF)));
      repeat (90) send_spring(rand_spring());
    end
  endtask

  // back-to-back items and results with no idling
  task automatic test_full_rate();
    no_idle = 1'b1;
    repeat (250) send_spring(rand_spring());
    no_idle = 1'b0;
  endtask

  // result checker and receiver stalls
  initial begin : result_check
    spring_eval_t got, exp_e;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got.energy = res_if.energy;
        got.grad   = {res_if.grad_x, res_if.grad_y, res_if.grad_z};
        got.hess   = {res_if.hess_xx, res_if.hess_xy, res_if.hess_xz,
                      res_if.hess_yy, res_if.hess_yz, res_if.hess_zz};
        got.deg    = res_if.degenerate;
        if (expected_evals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_e = expected_evals.pop_front();
          if (got !== exp_e) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch energy exp %h got %h deg exp %b got %b",
                       exp_e.energy, got.energy, exp_e.deg, got.deg);
              for (int i = 0; i < 3; i++)
                $display("  grad[%0d] exp %h got %h", i, exp_e.grad[2-i], got.grad[2-i]);
              for (int i = 0; i < 6; i++)
                $display("  hess[%0d] exp %h got %h", i, exp_e.hess[5-i], got.hess[5-i]);
            end
          end
        end
      end
      @(negedge clk);
      res_if.ready = rst ? 1'b0 : (no_idle || $urandom_range(0, 99) >= 21);
    end
  end

  // watchdog on cycles without any accepted item, result or register write
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((pts_if.valid && pts_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    mismatches      = 0;
    no_idle         = 1'b0;
    rest_q          = REG_RESET;
    stiff_q         = REG_RESET;
    rst             = 1'b1;
    pts_if.valid    = 1'b0;
    pts_if.first_x  = '0;
    pts_if.first_y  = '0;
    pts_if.first_z  = '0;
    pts_if.second_x = '0;
    pts_if.second_y = '0;
    pts_if.second_z = '0;
    res_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_config_corners();
    test_random_springs();
    test_full_rate();

    @(negedge clk);
    pts_if.valid = 1'b0;
    wait (expected_evals.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_evals.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
